// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker modules of this block.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csq assertion failed");

`endif

// ----- design/csq_pkg.sv -----
// Package for the contrast stretch quantizer: payload structs, sequencer states,
// arithmetic constants and the level quantizer. No dependencies.
package csq_pkg;

   typedef struct packed {
      logic       req_type;
      logic       frame_start;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } csq_req_type;

   typedef struct packed {
      logic [7:0] level;
      logic       flat_frame;
   } csq_rsp_type;

   // Pixel kinds carried in req_type.
   localparam logic PIX_MEASURE = 1'b0;
   localparam logic PIX_MAP     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LUMA,
      ST_MEAS,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } csq_state_type;

   // Divider handshake between sequencer and divide unit.
   typedef struct packed {
      logic        start;
      logic [15:0] numer;
      logic [7:0]  denom;
   } csq_div_ctl_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quot;
   } csq_div_sts_type;

   localparam int unsigned DIV_STEPS = 8;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Divide by 3 as multiply by 683 and shift by 11; exact for sums up to 765.
   localparam logic [9:0] LUMA_RECIP = 10'd683;
   localparam int unsigned LUMA_SHIFT = 11;

   // Divide by 25 as multiply by 41 and shift by 10; exact for values up to 267.
   localparam logic [5:0] QUANT_RECIP = 6'd41;
   localparam int unsigned QUANT_SHIFT = 10;

   localparam logic [7:0] STEP       = 8'd25;
   localparam logic [8:0] HALF_STEP  = 9'd12;
   localparam logic [7:0] FULL_SCALE = 8'd255;
   localparam logic [7:0] DARK_RESET = 8'd255;
   localparam logic [7:0] BRIGHT_RESET = 8'd0;

   // Round to the nearest multiple of 25, upward when the remainder exceeds 12.
   function automatic logic [7:0] quantize(input logic [7:0] v);
      logic [8:0]  biased;
      logic [15:0] prod;
      logic [3:0]  q;
      biased = {1'b0, v} + HALF_STEP;
      prod   = 16'(biased) * 16'(QUANT_RECIP);
      q      = prod[QUANT_SHIFT+3:QUANT_SHIFT];
      return 8'(12'(q) * 12'(STEP));
   endfunction

endpackage

// ----- design/csq_divider.sv -----
// Restoring divider: 16-bit numerator by 8-bit divisor, 8-bit quotient,
// one quotient bit per cycle. Depends on csq_pkg.
module csq_divider
   import csq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csq_div_ctl_type ctl,
   output csq_div_sts_type sts
);

   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           low_ff, low_in;
   logic [7:0]           den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [8:0] trial;
   logic [8:0] diff;
   logic       fits;

   always_comb begin
      trial = {rem_ff, low_ff[7]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctl.start) begin
         // Upper byte is already below the divisor since the quotient fits 8 bits.
         rem_in  = ctl.numer[15:8];
         low_in  = ctl.numer[7:0];
         den_in  = ctl.denom;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[7:0] : trial[7:0];
         low_in = {low_ff[6:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign sts.done = done_ff;
   assign sts.quot = low_ff;

endmodule

// ----- design/contrast_stretch_quantize.sv -----
// Contrast stretch quantizer. Takes one RGB pixel item at a time and is not
// ready while it works on it. A measure item (req_type 0) runs these steps
// from acceptance until req_ready returns: register the channel sum, form the
// brightness, fold it into the running darkest/brightest pair. A map item
// (req_type 1) runs sum, brightness, clamp and numerator setup, the
// bit-serial divider (one quotient bit per cycle), the divider's completion
// flag, and finally rounding to a multiple of 25 and loading the output
// register. A flat or unmeasured frame skips the divider. The result sits in
// an output register, so a finished item waits there while the next pixel is
// taken; the block stalls in its final step only while that register is
// still full. Depends on csq_pkg and csq_divider.
module contrast_stretch_quantize
   import csq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  csq_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output csq_rsp_type rsp_payload
);

   csq_state_type state_ff, state_in;

   // Captured item fields.
   logic       kind_ff, kind_in;
   logic       fs_ff, fs_in;
   logic [9:0] sum_ff, sum_in;
   logic [7:0] lum_ff, lum_in;
   logic       flat_ff, flat_in;

   // Frame statistics.
   logic [7:0] bright_ff, bright_in;
   logic [7:0] dark_ff, dark_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   csq_rsp_type rsp_ff, rsp_in;

   logic [19:0] lum_prod;
   logic [7:0]  clamped;
   logic [7:0]  offset;

   csq_div_ctl_type div_ctl;
   csq_div_sts_type div_sts;

   csq_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign lum_prod = 20'(sum_ff) * 20'(LUMA_RECIP);

   // Saturate the brightness into the measured range before stretching.
   always_comb begin
      if (lum_ff < dark_ff) begin
         clamped = dark_ff;
      end else if (lum_ff > bright_ff) begin
         clamped = bright_ff;
      end else begin
         clamped = lum_ff;
      end
      offset = clamped - dark_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bright_ff    <= BRIGHT_RESET;
         dark_ff      <= DARK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bright_ff    <= bright_in;
         dark_ff      <= dark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      fs_ff   <= fs_in;
      sum_ff  <= sum_in;
      lum_ff  <= lum_in;
      flat_ff <= flat_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      fs_in        = fs_ff;
      sum_in       = sum_ff;
      lum_in       = lum_ff;
      flat_in      = flat_ff;
      bright_in    = bright_ff;
      dark_in      = dark_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      div_ctl      = '{start: 1'b0, numer: {offset, 8'd0} - {8'd0, offset}, denom: bright_ff - dark_ff};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_payload.req_type;
               fs_in    = req_payload.frame_start;
               sum_in   = {2'd0, req_payload.red} + {2'd0, req_payload.green}
                        + {2'd0, req_payload.blue};
               state_in = ST_LUMA;
            end
         end
         ST_LUMA: begin
            lum_in   = lum_prod[LUMA_SHIFT+7:LUMA_SHIFT];
            state_in = (kind_ff == PIX_MAP) ? ST_PREP : ST_MEAS;
         end
         ST_MEAS: begin
            // A frame start clears the pair first, so both take this brightness.
            if (fs_ff) begin
               bright_in = lum_ff;
               dark_in   = lum_ff;
            end else begin
               if (lum_ff > bright_ff) begin
                  bright_in = lum_ff;
               end
               if (lum_ff < dark_ff) begin
                  dark_in = lum_ff;
               end
            end
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            // No usable range: skip the divider and report a flat frame.
            if (bright_ff <= dark_ff) begin
               flat_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               flat_in       = 1'b0;
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the output register is free, then load it.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.flat_frame = flat_ff;
               rsp_in.level      = flat_ff ? 8'd0 : quantize(div_sts.quot);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- design/csq_checker.sv -----
// Port-level checker for the contrast stretch quantizer, bound to the top level.
// Depends on csq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csq_checker
   import csq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input csq_req_type req_payload,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input csq_rsp_type rsp_payload
);

   // A stalled result item holds its value.
   `CSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Block is busy right after taking an item.
   `CSQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // A flat frame always reports level zero.
   `CSQ_ASSERT_SAME(a_flat_zero, rsp_valid && rsp_payload.flat_frame, rsp_payload.level == 8'd0)

   // Quantized level never exceeds the top step.
   `CSQ_ASSERT_SAME(a_level_range, rsp_valid, rsp_payload.level <= 8'd250)

endmodule

bind contrast_stretch_quantize csq_checker u_csq_checker (.*);
